/* src/odr_pkg.sv */
// shared types, constants and helper functions of the occluder box depth raster
`default_nettype none

package odr_pkg;

    // fixed field widths
    localparam int Q_W        = 32;
    localparam int PIX_W      = 7;
    localparam int DIM_W      = 11;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;
    localparam int ACC_W      = 50;
    localparam int DIV_N_W    = 48;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic signed [Q_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_RASTER = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } odr_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MAT_MUL,
        ST_MAT_ACC,
        ST_CORNER,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MAP_MUL,
        ST_MAP_ACC,
        ST_MERGE,
        ST_RECT,
        ST_BASE_MUL,
        ST_BASE_ACC,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_READ_MUL,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_DONE
    } odr_state_t;

    typedef struct packed {
        logic signed [Q_W-1:0]   depth_read;
        logic                    drawn;
        logic [PIX_W-1:0]        rect_left;
        logic [PIX_W-1:0]        rect_top;
        logic [PIX_W-1:0]        rect_right;
        logic [PIX_W-1:0]        rect_bottom;
        logic signed [Q_W-1:0]   box_depth;
    } odr_res_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic done;
    } odr_div_ctl_t;

    // saturate a wide product to Q16.16
    function automatic logic signed [Q_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-Q_W:0] hi;
        hi = v[PROD_W-1:Q_W-1];
        if (hi == '0 || hi == '1)
            return v[Q_W-1:0];
        else if (v[PROD_W-1])
            return Q_MIN;
        else
            return Q_MAX;
    endfunction

    // saturate the dot product sum to Q16.16
    function automatic logic signed [Q_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-Q_W:0] hi;
        hi = v[ACC_W-1:Q_W-1];
        if (hi == '0 || hi == '1)
            return v[Q_W-1:0];
        else if (v[ACC_W-1])
            return Q_MIN;
        else
            return Q_MAX;
    endfunction

endpackage

`default_nettype wire

/* src/odr_if.sv */
// channel interfaces: command, response and configuration write
`default_nettype none

interface odr_cmd_if;
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [1:0]          row_index;
    logic signed [31:0]  val_a;
    logic signed [31:0]  val_b;
    logic signed [31:0]  val_c;
    logic signed [31:0]  val_d;
    logic signed [31:0]  val_e;
    logic signed [31:0]  val_f;
    logic [6:0]          pixel_x;
    logic [6:0]          pixel_y;

    modport source (output valid, command, row_index, val_a, val_b, val_c, val_d, val_e,
                    val_f, pixel_x, pixel_y, input ready);
    modport sink   (input valid, command, row_index, val_a, val_b, val_c, val_d, val_e,
                    val_f, pixel_x, pixel_y, output ready);
endinterface

interface odr_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  depth_read;
    logic                drawn;
    logic [6:0]          rect_left;
    logic [6:0]          rect_top;
    logic [6:0]          rect_right;
    logic [6:0]          rect_bottom;
    logic signed [31:0]  box_depth;

    modport source (output valid, depth_read, drawn, rect_left, rect_top, rect_right,
                    rect_bottom, box_depth, input ready);
    modport sink   (input valid, depth_read, drawn, rect_left, rect_top, rect_right,
                    rect_bottom, box_depth, output ready);
endinterface

interface odr_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [7:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/odr_mul.sv */
// shared signed multiplier with registered product
`default_nettype none

module odr_mul (
    input  wire logic                               clk,
    input  wire logic signed [odr_pkg::MUL_W-1:0]   a,
    input  wire logic signed [odr_pkg::MUL_W-1:0]   b,
    output logic signed [odr_pkg::PROD_W-1:0]       prod_reg
);
    import odr_pkg::*;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

`default_nettype wire

/* src/odr_div.sv */
// iterative divider: saturated (num * 2^16) / den, one quotient bit per cycle
`default_nettype none

module odr_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [odr_pkg::Q_W-1:0]  num,
    input  wire logic signed [odr_pkg::Q_W-1:0]  den,
    output logic                                 done,
    output logic signed [odr_pkg::Q_W-1:0]       quot
);
    import odr_pkg::*;

    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [Q_W:0]            rem_reg, rem_next;
    logic [DIV_N_W-1:0]      nq_reg, nq_next;
    logic [Q_W-1:0]          den_reg, den_next;
    logic                    neg_reg, neg_next;
    logic [Q_W:0]            rem_sh;
    logic [DIV_N_W-1:0]      nq_neg;
    logic [Q_W-1:0]          num_mag;

    // control and datapath next values
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[Q_W-1:0], nq_reg[DIV_N_W-1]};
        num_mag   = num[Q_W-1] ? (~num + 1'b1) : num;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            nq_next  = {num_mag, 16'h0000};
            den_next = den[Q_W-1] ? (~den + 1'b1) : den;
            neg_next = num[Q_W-1] ^ den[Q_W-1];
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                nq_next  = {nq_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                nq_next  = {nq_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // sign and saturation of the quotient
    always_comb
    begin
        nq_neg = ~nq_reg + 1'b1;
        if (neg_reg)
            quot = (nq_reg > DIV_N_W'(48'h0000_8000_0000)) ? Q_MIN : nq_neg[Q_W-1:0];
        else
            quot = (nq_reg > DIV_N_W'(48'h0000_7FFF_FFFF)) ? Q_MAX : nq_reg[Q_W-1:0];
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* src/odr_depth_mem.sv */
// depth store: one write port, one registered read port
`default_nettype none

module odr_depth_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [AW-1:0]                   waddr,
    input  wire logic signed [odr_pkg::Q_W-1:0]  wdata,
    input  wire logic [AW-1:0]                   raddr,
    output logic signed [odr_pkg::Q_W-1:0]       rdata_reg
);
    import odr_pkg::*;

    logic signed [Q_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/occluder_box_depth_raster.sv */
// Occluder box depth raster: top level with sequencer, shared multiplier and divider
//
// Channels: cmd (valid/ready) takes one command per transfer: load matrix row,
// rasterize box, clear store or read one depth. rsp (valid/ready) returns one
// result per command. cfg (valid/ready, always ready) writes screen_width
// (index 0) and screen_height (index 1); other indexes are ignored.
// One command is worked on at a time; cmd.ready is high only when idle.
// Rasterizing is paced by the one shared 33x33 multiplier (16 products per
// corner), the bit-serial divider (up to three divides per corner) and the
// separate read and write ports of the depth store (read then write per pixel).
// After reset the block clears the depth store to 1.0, one entry per cycle;
// no command is taken meanwhile.
// Results sit in an output register; while rsp stalls, the next command is
// still accepted and worked on, and its result waits until the register frees.
`default_nettype none

module occluder_box_depth_raster #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    odr_cmd_if.sink      cmd,
    odr_rsp_if.source    rsp,
    odr_cfg_if.sink      cfg
);
    import odr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // control state
    odr_state_t            state_reg, state_next;
    logic [2:0]            corner_reg, corner_next;
    logic [1:0]            ti_reg, ti_next;
    logic [1:0]            tj_reg, tj_next;
    logic [1:0]            dsel_reg, dsel_next;
    logic                  msel_reg, msel_next;
    logic [DIM_W-1:0]      xc_reg, xc_next;
    logic [DIM_W-1:0]      yc_reg, yc_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic                  clr_cmd_reg, clr_cmd_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CFG_DATA_W-1:0] width_reg, height_reg;

    // datapath
    logic signed [Q_W-1:0]   mat_reg [16];
    logic signed [Q_W-1:0]   bv_reg [6];
    logic [PIX_W-1:0]        px_reg, py_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [Q_W-1:0]   clip_reg [4];
    logic signed [Q_W-1:0]   ndc_reg [3];
    logic signed [Q_W-1:0]   sx_reg, sy_reg;
    logic signed [Q_W-1:0]   minx_reg, maxx_reg, miny_reg, maxy_reg, minz_reg;
    logic                    any_reg;
    logic [DIM_W-1:0]        x0_reg, x1_reg, y0_reg, y1_reg;
    logic [AW-1:0]           base_reg;
    odr_res_t                work_reg;
    odr_res_t                out_reg;

    logic                    cmd_fire;
    logic                    out_load;
    logic [DIM_W-1:0]        eff_w, eff_h, wm1, hm1;
    logic [DIM_W-1:0]        pxc, pyc;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [Q_W-1:0]   p_sel;
    logic signed [Q_W-1:0]   map_val;
    odr_div_ctl_t            div_ctl;
    logic signed [Q_W-1:0]   div_q;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr, mem_raddr, walk_addr;
    logic signed [Q_W-1:0]   mem_wdata, mem_rdata;
    logic signed [Q_W:0]     xs, ys;
    logic signed [17:0]      x0e, x1e, y0e, y1e, wm1e, hm1e;
    logic                    nonempty;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    // effective screen size, clamped to 1..MAX
    always_comb
    begin
        if (width_reg == '0)
            eff_w = DIM_W'(1);
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
            eff_w = DIM_W'(MAX_WIDTH);
        else
            eff_w = DIM_W'(width_reg);
        if (height_reg == '0)
            eff_h = DIM_W'(1);
        else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT))
            eff_h = DIM_W'(MAX_HEIGHT);
        else
            eff_h = DIM_W'(height_reg);
        wm1 = eff_w - DIM_W'(1);
        hm1 = eff_h - DIM_W'(1);
        pxc = (DIM_W'(px_reg) > wm1) ? wm1 : DIM_W'(px_reg);
        pyc = (DIM_W'(py_reg) > hm1) ? hm1 : DIM_W'(py_reg);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg.data;
                REG_SCREEN_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // corner coordinate for the current matrix term
    always_comb
    begin
        case (ti_reg)
            2'd0:    p_sel = corner_reg[0] ? bv_reg[3] : bv_reg[0];
            2'd1:    p_sel = corner_reg[1] ? bv_reg[4] : bv_reg[1];
            2'd2:    p_sel = corner_reg[2] ? bv_reg[5] : bv_reg[2];
            default: p_sel = Q_ONE;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MAT_MUL:
            begin
                mul_a = MUL_W'(p_sel);
                mul_b = MUL_W'(mat_reg[{ti_reg, tj_reg}]);
            end
            ST_MAP_MUL:
            begin
                if (!msel_reg)
                begin
                    mul_a = MUL_W'(ndc_reg[0]) + MUL_W'(Q_ONE);
                    mul_b = MUL_W'(eff_w);
                end
                else
                begin
                    mul_a = MUL_W'(Q_ONE) - MUL_W'(ndc_reg[1]);
                    mul_b = MUL_W'(eff_h);
                end
            end
            ST_BASE_MUL:
            begin
                mul_a = MUL_W'(y0_reg);
                mul_b = MUL_W'(eff_w);
            end
            ST_READ_MUL:
            begin
                mul_a = MUL_W'(pyc);
                mul_b = MUL_W'(eff_w);
            end
            default: ;
        endcase
    end

    odr_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    assign div_ctl.start = (state_reg == ST_DIV_GO);

    odr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_ctl.start),
        .num   (clip_reg[dsel_reg]),
        .den   (clip_reg[3]),
        .done  (div_ctl.done),
        .quot  (div_q)
    );

    // depth store ports
    assign walk_addr = base_reg + AW'(xc_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_addr;
        mem_wdata = minz_reg;
        mem_raddr = walk_addr;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = Q_ONE;
        end
        else if (state_reg == ST_WALK_WR)
            mem_we = (mem_rdata > minz_reg);
        if (state_reg == ST_READ_ADDR)
            mem_raddr = prod[AW-1:0] + AW'(pxc);
    end

    odr_depth_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .raddr     (mem_raddr),
        .rdata_reg (mem_rdata)
    );

    // arithmetic helpers
    assign acc_sum = acc_reg + prod[PROD_W-1:16];
    assign map_val = sat_prod({prod[PROD_W-1], prod[PROD_W-1:1]});

    // bounding rectangle: floor of minimum, ceiling of maximum, clamp to screen
    always_comb
    begin
        xs   = (Q_W+1)'(maxx_reg) + 33'sd65535;
        ys   = (Q_W+1)'(maxy_reg) + 33'sd65535;
        wm1e = 18'($signed({1'b0, wm1}));
        hm1e = 18'($signed({1'b0, hm1}));
        x0e  = 18'($signed(minx_reg[Q_W-1:16]));
        y0e  = 18'($signed(miny_reg[Q_W-1:16]));
        x1e  = 18'($signed(xs[Q_W:16]));
        y1e  = 18'($signed(ys[Q_W:16]));
        if (x0e < 18'sd0)
            x0e = 18'sd0;
        if (y0e < 18'sd0)
            y0e = 18'sd0;
        if (x1e > wm1e)
            x1e = wm1e;
        if (y1e > hm1e)
            y1e = hm1e;
        nonempty = any_reg && (x0e <= x1e) && (y0e <= y1e);
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // sequencer: next state and counters
    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        ti_next        = ti_reg;
        tj_next        = tj_reg;
        dsel_next      = dsel_reg;
        msel_next      = msel_reg;
        xc_next        = xc_reg;
        yc_next        = yc_reg;
        clr_next       = clr_reg;
        clr_cmd_next   = clr_cmd_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (odr_cmd_t'(cmd.command))
                        CMD_LOAD:
                            state_next = ST_DONE;
                        CMD_RASTER:
                        begin
                            corner_next = '0;
                            ti_next     = '0;
                            tj_next     = '0;
                            state_next  = ST_MAT_MUL;
                        end
                        CMD_CLEAR:
                        begin
                            clr_next     = '0;
                            clr_cmd_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default:
                            state_next = ST_READ_MUL;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = clr_cmd_reg ? ST_DONE : ST_IDLE;
            end
            ST_MAT_MUL:
                state_next = ST_MAT_ACC;
            ST_MAT_ACC:
            begin
                ti_next    = ti_reg + 1'b1;
                state_next = ST_MAT_MUL;
                if (ti_reg == 2'd3)
                begin
                    tj_next = tj_reg + 1'b1;
                    if (tj_reg == 2'd3)
                        state_next = ST_CORNER;
                end
            end
            ST_CORNER:
            begin
                if (clip_reg[3] == '0)
                begin
                    corner_next = corner_reg + 1'b1;
                    state_next  = (corner_reg == 3'd7) ? ST_RECT : ST_MAT_MUL;
                end
                else
                begin
                    dsel_next  = '0;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_ctl.done)
                begin
                    dsel_next = dsel_reg + 1'b1;
                    if (dsel_reg == 2'd2)
                    begin
                        msel_next  = 1'b0;
                        state_next = ST_MAP_MUL;
                    end
                    else
                        state_next = ST_DIV_GO;
                end
            end
            ST_MAP_MUL:
                state_next = ST_MAP_ACC;
            ST_MAP_ACC:
            begin
                msel_next  = 1'b1;
                state_next = msel_reg ? ST_MERGE : ST_MAP_MUL;
            end
            ST_MERGE:
            begin
                corner_next = corner_reg + 1'b1;
                state_next  = (corner_reg == 3'd7) ? ST_RECT : ST_MAT_MUL;
            end
            ST_RECT:
            begin
                xc_next    = DIM_W'(x0e);
                yc_next    = DIM_W'(y0e);
                state_next = nonempty ? ST_BASE_MUL : ST_DONE;
            end
            ST_BASE_MUL:
                state_next = ST_BASE_ACC;
            ST_BASE_ACC:
                state_next = ST_WALK_RD;
            ST_WALK_RD:
                state_next = ST_WALK_WR;
            ST_WALK_WR:
            begin
                state_next = ST_WALK_RD;
                if (xc_reg == x1_reg)
                begin
                    xc_next = x0_reg;
                    yc_next = yc_reg + 1'b1;
                    if (yc_reg == y1_reg)
                        state_next = ST_DONE;
                end
                else
                    xc_next = xc_reg + 1'b1;
            end
            ST_READ_MUL:
                state_next = ST_READ_ADDR;
            ST_READ_ADDR:
                state_next = ST_READ_DATA;
            ST_READ_DATA:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    clr_cmd_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            corner_reg    <= '0;
            ti_reg        <= '0;
            tj_reg        <= '0;
            dsel_reg      <= '0;
            msel_reg      <= 1'b0;
            xc_reg        <= '0;
            yc_reg        <= '0;
            clr_reg       <= '0;
            clr_cmd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            corner_reg    <= corner_next;
            ti_reg        <= ti_next;
            tj_reg        <= tj_next;
            dsel_reg      <= dsel_next;
            msel_reg      <= msel_next;
            xc_reg        <= xc_next;
            yc_reg        <= yc_next;
            clr_reg       <= clr_next;
            clr_cmd_reg   <= clr_cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transform matrix, cleared by reset, one row per load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= '0;
        end
        else if (cmd_fire && odr_cmd_t'(cmd.command) == CMD_LOAD)
        begin
            mat_reg[{cmd.row_index, 2'd0}] <= cmd.val_a;
            mat_reg[{cmd.row_index, 2'd1}] <= cmd.val_b;
            mat_reg[{cmd.row_index, 2'd2}] <= cmd.val_c;
            mat_reg[{cmd.row_index, 2'd3}] <= cmd.val_d;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    bv_reg[0] <= cmd.val_a;
                    bv_reg[1] <= cmd.val_b;
                    bv_reg[2] <= cmd.val_c;
                    bv_reg[3] <= cmd.val_d;
                    bv_reg[4] <= cmd.val_e;
                    bv_reg[5] <= cmd.val_f;
                    px_reg    <= cmd.pixel_x;
                    py_reg    <= cmd.pixel_y;
                    work_reg  <= '0;
                    acc_reg   <= '0;
                    any_reg   <= 1'b0;
                    minz_reg  <= Q_ONE;
                    minx_reg  <= '0;
                    maxx_reg  <= '0;
                    miny_reg  <= '0;
                    maxy_reg  <= '0;
                end
            end
            ST_MAT_ACC:
            begin
                if (ti_reg == 2'd3)
                begin
                    clip_reg[tj_reg] <= sat_acc(acc_sum);
                    acc_reg          <= '0;
                end
                else
                    acc_reg <= acc_sum;
            end
            ST_DIV_WAIT:
            begin
                if (div_ctl.done)
                    ndc_reg[dsel_reg] <= div_q;
            end
            ST_MAP_ACC:
            begin
                if (msel_reg)
                    sy_reg <= map_val;
                else
                    sx_reg <= map_val;
            end
            ST_MERGE:
            begin
                any_reg <= 1'b1;
                if (!any_reg || sx_reg < minx_reg)
                    minx_reg <= sx_reg;
                if (!any_reg || sx_reg > maxx_reg)
                    maxx_reg <= sx_reg;
                if (!any_reg || sy_reg < miny_reg)
                    miny_reg <= sy_reg;
                if (!any_reg || sy_reg > maxy_reg)
                    maxy_reg <= sy_reg;
                if (ndc_reg[2] < minz_reg)
                    minz_reg <= ndc_reg[2];
            end
            ST_RECT:
            begin
                x0_reg                <= DIM_W'(x0e);
                x1_reg                <= DIM_W'(x1e);
                y0_reg                <= DIM_W'(y0e);
                y1_reg                <= DIM_W'(y1e);
                work_reg.box_depth    <= minz_reg;
                work_reg.drawn        <= nonempty;
                work_reg.rect_left    <= nonempty ? PIX_W'(x0e) : '0;
                work_reg.rect_top     <= nonempty ? PIX_W'(y0e) : '0;
                work_reg.rect_right   <= nonempty ? PIX_W'(x1e) : '0;
                work_reg.rect_bottom  <= nonempty ? PIX_W'(y1e) : '0;
            end
            ST_BASE_ACC:
                base_reg <= prod[AW-1:0];
            ST_WALK_WR:
            begin
                if (xc_reg == x1_reg)
                    base_reg <= base_reg + AW'(eff_w);
            end
            ST_READ_DATA:
                work_reg.depth_read <= mem_rdata;
            default: ;
        endcase
        if (out_load)
            out_reg <= work_reg;
    end

    // response port
    assign rsp.valid       = out_valid_reg;
    assign rsp.depth_read  = out_reg.depth_read;
    assign rsp.drawn       = out_reg.drawn;
    assign rsp.rect_left   = out_reg.rect_left;
    assign rsp.rect_top    = out_reg.rect_top;
    assign rsp.rect_right  = out_reg.rect_right;
    assign rsp.rect_bottom = out_reg.rect_bottom;
    assign rsp.box_depth   = out_reg.box_depth;

endmodule

`default_nettype wire

/* src/odr_checker.sv */
// port-level checks of the occluder box depth raster and their binding
`default_nettype none

module odr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_valid,
    input wire logic        cmd_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        drawn,
    input wire logic [6:0]  rect_left,
    input wire logic [6:0]  rect_top,
    input wire logic [6:0]  rect_right,
    input wire logic [6:0]  rect_bottom,
    input wire logic [31:0] box_depth
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(box_depth) && $stable(drawn))
        else $error("stalled result changed");

    // an undrawn result reports an all-zero rectangle
    a_empty_rect: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !drawn |-> rect_left == 7'd0 && rect_top == 7'd0 &&
                                rect_right == 7'd0 && rect_bottom == 7'd0)
        else $error("rectangle not zero while not drawn");

    // a drawn rectangle is ordered
    a_rect_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && drawn |-> rect_left <= rect_right && rect_top <= rect_bottom)
        else $error("drawn rectangle out of order");

    // one command at a time: busy right after a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while busy");

endmodule

bind occluder_box_depth_raster odr_checker u_odr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .drawn       (rsp.drawn),
    .rect_left   (rsp.rect_left),
    .rect_top    (rsp.rect_top),
    .rect_right  (rsp.rect_right),
    .rect_bottom (rsp.rect_bottom),
    .box_depth   (rsp.box_depth)
);

`default_nettype wire
